// ===== rtl/smenum_pkg.sv =====
// shared types, constants and the microcode rom of the stable matching enumerator
`default_nettype none

package smenum_pkg;

  localparam int PEOPLE_DEFAULT = 3;
  localparam int TABLE_W        = 18;
  localparam int WIVES_W        = 6;
  localparam int OUT_MEN        = WIVES_W / 2;
  localparam int SOL_W          = 3;
  localparam int MAX_RESULTS    = 7;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam logic [TABLE_W-1:0] MEN_RANK_RESET   = 18'd38424;
  localparam logic [TABLE_W-1:0] WOMEN_RANK_RESET = 18'd76038;

  typedef enum logic {
    REG_MEN_RANK,
    REG_WOMEN_RANK
  } reg_idx_t;

  // microcode steps
  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_TRY,
    S_CHK,
    S_CHKRD,
    S_CHKEV,
    S_REJECT,
    S_ACCEPT,
    S_DESCEND,
    S_SOLN,
    S_FLUSH,
    S_PACK,
    S_PACKRD,
    S_PACKWR,
    S_COUNT,
    S_RETRY,
    S_BACK,
    S_BACKRD,
    S_BACKLD,
    S_FINAL,
    S_END
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_CI_CLR,
    OP_RD_CI,
    OP_CI_INC,
    OP_WC_INC,
    OP_WR_PA,
    OP_DESCEND,
    OP_PUSH_MID,
    OP_PACK_CLR,
    OP_PACK,
    OP_SOL_INC,
    OP_ASCEND,
    OP_RD_C,
    OP_LOAD_WC,
    OP_PUSH_LAST
  } dp_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_WC_FULL,
    C_CI_EQ_C,
    C_NOT_BLOCKED,
    C_C_LAST,
    C_NO_PENDING,
    C_OUT_BUSY,
    C_CI_NOT_LAST,
    C_SOL_SIX,
    C_C_ZERO
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    logic wc_full;
    logic ci_eq_c;
    logic blocked;
    logic c_last;
    logic c_zero;
    logic ci_last;
    logic no_pending;
    logic sol_six;
    logic out_busy;
  } dp_status_t;

  // control store: op for this step, jump condition, jump target
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      S_IDLE:    w = '{OP_NOP,       C_NO_START,    S_IDLE};
      S_INIT:    w = '{OP_INIT,      C_NEVER,       S_IDLE};
      S_TRY:     w = '{OP_NOP,       C_WC_FULL,     S_BACK};
      S_CHK:     w = '{OP_CI_CLR,    C_NEVER,       S_IDLE};
      S_CHKRD:   w = '{OP_RD_CI,     C_CI_EQ_C,     S_ACCEPT};
      S_CHKEV:   w = '{OP_CI_INC,    C_NOT_BLOCKED, S_CHKRD};
      S_REJECT:  w = '{OP_WC_INC,    C_ALWAYS,      S_TRY};
      S_ACCEPT:  w = '{OP_WR_PA,     C_C_LAST,      S_SOLN};
      S_DESCEND: w = '{OP_DESCEND,   C_ALWAYS,      S_TRY};
      S_SOLN:    w = '{OP_NOP,       C_NO_PENDING,  S_PACK};
      S_FLUSH:   w = '{OP_PUSH_MID,  C_OUT_BUSY,    S_FLUSH};
      S_PACK:    w = '{OP_PACK_CLR,  C_NEVER,       S_IDLE};
      S_PACKRD:  w = '{OP_RD_CI,     C_NEVER,       S_IDLE};
      S_PACKWR:  w = '{OP_PACK,      C_CI_NOT_LAST, S_PACKRD};
      S_COUNT:   w = '{OP_SOL_INC,   C_SOL_SIX,     S_FINAL};
      S_RETRY:   w = '{OP_WC_INC,    C_ALWAYS,      S_TRY};
      S_BACK:    w = '{OP_ASCEND,    C_C_ZERO,      S_FINAL};
      S_BACKRD:  w = '{OP_RD_C,      C_NEVER,       S_IDLE};
      S_BACKLD:  w = '{OP_LOAD_WC,   C_ALWAYS,      S_TRY};
      S_FINAL:   w = '{OP_PUSH_LAST, C_OUT_BUSY,    S_FINAL};
      S_END:     w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
      default:   w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

  // 2-bit rank entry; entries past the table read as zero
  function automatic logic [1:0] rank_at(input logic [TABLE_W-1:0] tab, input logic [3:0] idx);
    logic [31:0] ext;
    ext = 32'(tab);
    return ext[{idx, 1'b0} +: 2];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stable_matching_enumerator.sv =====
// top level: rank table registers, sequencer and datapath
//
//   channel  | direction | handshake          | word
//   in       | to block  | in_valid/in_ready  | start_request
//   out      | from block| out_valid/out_ready| wives_packed, solution_number, found, last
//   apb      | to block  | psel/penable/pready| men_rank_table @0x0, women_rank_table @0x4
//
// a start word runs the whole search; in_ready stays low after the last push, through S_END, until S_IDLE.
// each wife tried is checked against every earlier man in turn and rejected at the first clash or
// blocking pair; each matching is packed man by man after the word of the one before is pushed.
// a start word with start_request low is taken while idle and gives no word.
// out_ready low stalls the sequencer only where it pushes a word.
// synchronous reset restores the default rank tables; the assignment store needs no clearing.
`default_nettype none

module stable_matching_enumerator import smenum_pkg::*; #(
  parameter int PEOPLE = PEOPLE_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  start_request,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [WIVES_W-1:0]         wives_packed,
  output logic [SOL_W-1:0]           solution_number,
  output logic                       found,
  output logic                       last,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [TABLE_W-1:0] men_tab;
  logic [TABLE_W-1:0] women_tab;
  reg_idx_t           reg_idx;
  dp_op_t             op;
  dp_status_t         status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      men_tab   <= MEN_RANK_RESET;
      women_tab <= WOMEN_RANK_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MEN_RANK:   men_tab   <= pwdata[TABLE_W-1:0];
        REG_WOMEN_RANK: women_tab <= pwdata[TABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MEN_RANK:   prdata = APB_DATA_W'(men_tab);
      REG_WOMEN_RANK: prdata = APB_DATA_W'(women_tab);
      default:        prdata = '0;
    endcase
  end

  smenum_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .start_request (start_request),
    .status        (status),
    .in_ready      (in_ready),
    .op            (op)
  );

  smenum_dp #(
    .PEOPLE (PEOPLE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .men_tab         (men_tab),
    .women_tab       (women_tab),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .wives_packed    (wives_packed),
    .solution_number (solution_number),
    .found           (found),
    .last            (last)
  );

endmodule

`default_nettype wire

// ===== rtl/smenum_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module smenum_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 3
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/smenum_seq.sv =====
// microcode sequencer: step counter, control store and jump logic
`default_nettype none

module smenum_seq import smenum_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       start_request,
  input  wire dp_status_t status,
  output logic            in_ready,
  output dp_op_t          op
);

  step_t  upc;
  step_t  upc_next;
  ucode_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // output side of the sequencer
  always_comb begin
    uw       = ucode_rom(upc);
    op       = uw.op;
    in_ready = (upc == S_IDLE);
  end

  // jump condition and next step
  always_comb begin
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_START:    take = !(in_valid && start_request);
      C_WC_FULL:     take = status.wc_full;
      C_CI_EQ_C:     take = status.ci_eq_c;
      C_NOT_BLOCKED: take = !status.blocked;
      C_C_LAST:      take = status.c_last;
      C_NO_PENDING:  take = status.no_pending;
      C_OUT_BUSY:    take = status.out_busy;
      C_CI_NOT_LAST: take = !status.ci_last;
      C_SOL_SIX:     take = status.sol_six;
      C_C_ZERO:      take = status.c_zero;
      default:       take = 1'b1;
    endcase
    upc_next = take ? uw.target : step_t'(upc + 5'd1);
  end

endmodule

`default_nettype wire

// ===== rtl/smenum_dp.sv =====
// datapath: search registers, assignment store, blocking-pair test, result register
`default_nettype none

module smenum_dp import smenum_pkg::*; #(
  parameter int PEOPLE = PEOPLE_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_op_t             op,
  input  wire logic [TABLE_W-1:0] men_tab,
  input  wire logic [TABLE_W-1:0] women_tab,
  output dp_status_t              status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [WIVES_W-1:0]      wives_packed,
  output logic [SOL_W-1:0]        solution_number,
  output logic                    found,
  output logic                    last
);

  localparam int CW  = $clog2(PEOPLE);
  localparam int WCW = $clog2(PEOPLE + 1);

  logic [CW-1:0]      c;
  logic [CW-1:0]      ci;
  logic [WCW-1:0]     wc;
  logic [SOL_W-1:0]   sol;
  logic [WIVES_W-1:0] pend;

  logic               ram_we;
  logic [CW-1:0]      ram_raddr;
  logic [CW-1:0]      rdata;
  logic               out_busy;
  logic               push;

  logic [1:0] i2, c2, wi2, wc2;
  logic       clash;
  logic       earlier_prefers;
  logic       current_prefers;

  function automatic logic [3:0] ent(input logic [1:0] r, input logic [1:0] col);
    return 4'(r) * 4'(PEOPLE) + 4'(col);
  endfunction

  assign ram_we    = (op == OP_WR_PA);
  assign ram_raddr = (op == OP_RD_C) ? c : ci;

  smenum_ram #(
    .WIDTH (CW),
    .DEPTH (PEOPLE)
  ) u_pa (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c),
    .wdata (CW'(wc)),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // earlier man ci holds wife rdata, current man c tries wife wc
  always_comb begin
    i2  = 2'(ci);
    c2  = 2'(c);
    wi2 = 2'(rdata);
    wc2 = 2'(wc);
    clash = (rdata == CW'(wc));
    earlier_prefers =
      (rank_at(men_tab, ent(i2, wc2)) < rank_at(men_tab, ent(i2, wi2))) &&
      (rank_at(women_tab, ent(wc2, i2)) < rank_at(women_tab, ent(wc2, c2)));
    current_prefers =
      (rank_at(men_tab, ent(c2, wi2)) < rank_at(men_tab, ent(c2, wc2))) &&
      (rank_at(women_tab, ent(wi2, c2)) < rank_at(women_tab, ent(wi2, i2)));
  end

  assign out_busy = out_valid && !out_ready;
  assign push     = ((op == OP_PUSH_MID) || (op == OP_PUSH_LAST)) && !out_busy;

  always_comb begin
    status.wc_full    = (wc == WCW'(PEOPLE));
    status.ci_eq_c    = (ci == c);
    status.blocked    = clash || earlier_prefers || current_prefers;
    status.c_last     = (c == CW'(PEOPLE - 1));
    status.c_zero     = (c == '0);
    status.ci_last    = (ci == CW'(PEOPLE - 1));
    status.no_pending = (sol == '0);
    status.sol_six    = (sol == SOL_W'(MAX_RESULTS - 1));
    status.out_busy   = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c         <= '0;
      ci        <= '0;
      wc        <= '0;
      sol       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_INIT: begin
          c   <= '0;
          wc  <= '0;
          sol <= '0;
        end
        OP_CI_CLR, OP_PACK_CLR: begin
          ci <= '0;
        end
        OP_CI_INC, OP_PACK: begin
          ci <= ci + CW'(1);
        end
        OP_WC_INC: begin
          wc <= wc + WCW'(1);
        end
        OP_DESCEND: begin
          c  <= c + CW'(1);
          wc <= '0;
        end
        OP_SOL_INC: begin
          sol <= sol + SOL_W'(1);
        end
        OP_ASCEND: begin
          c <= c - CW'(1);
        end
        OP_LOAD_WC: begin
          wc <= WCW'(rdata) + WCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // packed wives of the newest matching, waiting until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (op == OP_PACK_CLR) begin
      pend <= '0;
    end else if (op == OP_PACK) begin
      for (int m = 0; m < OUT_MEN; m++) begin
        if ((m < PEOPLE) && (int'(ci) == m)) begin
          pend[2*m +: 2] <= 2'(rdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      wives_packed    <= (sol == '0) ? '0 : pend;
      solution_number <= sol;
      found           <= (sol != '0);
      last            <= (op == OP_PUSH_LAST);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smenum_chk.sv =====
// port-level checker for the stable matching enumerator, bound to the top level
`default_nettype none

module smenum_chk import smenum_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               start_request,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [WIVES_W-1:0] wives_packed,
  input wire logic [SOL_W-1:0]   solution_number,
  input wire logic               found,
  input wire logic               last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wives_packed) &&
      $stable(solution_number) && $stable(found) && $stable(last))
    else $error("result word changed while stalled");

  // the no-matching word is all zero and closes the run
  a_none_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && (solution_number == '0) && (wives_packed == '0))
    else $error("bad no-matching word");

  a_found_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (solution_number != '0))
    else $error("matching word without an ordinal");

  // a start keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_request |=> !in_ready)
    else $error("start word taken but block not busy");

  // a non-final word means the run is still going
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("block idle while run has not closed");

endmodule

bind stable_matching_enumerator smenum_chk u_chk (.*);

`default_nettype wire

// ===== dv/smenum_checker.sv =====
// checker: predicts the stable matchings of every start word and compares the output words
`timescale 1ns / 1ps

module smenum_checker import smenum_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  start_request,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [WIVES_W-1:0]    wives_packed,
  input  logic [SOL_W-1:0]      solution_number,
  input  logic                  found,
  input  logic                  last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  localparam int P = PEOPLE_DEFAULT;

  typedef struct packed {
    logic [WIVES_W-1:0] wives;
    logic [SOL_W-1:0]   number;
    logic               found;
    logic               last;
  } matching_t;

  matching_t          expected_matchings [$];
  logic [TABLE_W-1:0] men_tab;
  logic [TABLE_W-1:0] women_tab;
  int                 wife_of [P];
  int                 fail_count;

  // rank entry row*P+col of a packed table; entries past the register read as zero
  function automatic int rank_entry(input logic [TABLE_W-1:0] tab, input int row, input int col);
    int          idx;
    logic [31:0] wide;
    idx  = row * P + col;
    wide = 32'(tab);
    if (idx >= 16) return 0;
    return int'((wide >> (2 * idx)) & 32'd3);
  endfunction

  // wife of man c is distinct and makes no blocking pair with any earlier man
  function automatic bit fits_earlier_men(input int c);
    int wc;
    int wi;
    bit ok;
    ok = 1'b1;
    wc = wife_of[c];
    for (int i = 0; i < c; i++) begin
      wi = wife_of[i];
      if (ok) begin
        if (wi == wc) ok = 1'b0;
        else if ((rank_entry(men_tab, i, wc) < rank_entry(men_tab, i, wi) &&
                  rank_entry(women_tab, wc, i) < rank_entry(women_tab, wc, c)) ||
                 (rank_entry(men_tab, c, wi) < rank_entry(men_tab, c, wc) &&
                  rank_entry(women_tab, wi, c) < rank_entry(women_tab, wi, i)))
          ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // depth-first search over assignments, queueing every stable one in search order
  task automatic predict_matchings();
    int         c;
    int         count;
    int         pk;
    bit         stop;
    bit         placed;
    logic [SOL_W-1:0] sol;
    matching_t  m;
    sol   = '0;
    count = 0;
    stop  = 1'b0;
    for (int i = 0; i < P; i++) wife_of[i] = 0;
    c = 0;
    while (!stop) begin
      c++;
      if (c == P) begin
        pk = 0;
        for (int k = 0; k < P; k++) pk |= (wife_of[k] & 3) << (2 * k);
        sol      = sol + SOL_W'(1);
        m.wives  = pk[WIVES_W-1:0];
        m.number = sol;
        m.found  = 1'b1;
        m.last   = 1'b0;
        expected_matchings.push_back(m);
        count++;
        if (count == MAX_RESULTS) stop = 1'b1;
        else c--;
      end else begin
        wife_of[c] = -1;
      end
      if (!stop) begin
        placed = 1'b0;
        while (c >= 0 && !placed) begin
          wife_of[c]++;
          if (wife_of[c] >= P) c--;
          else if (fits_earlier_men(c)) placed = 1'b1;
        end
        if (c < 0) stop = 1'b1;
      end
    end
    if (count == 0) begin
      m = '0;
      m.last = 1'b1;
      expected_matchings.push_back(m);
    end else begin
      m = expected_matchings.pop_back();
      m.last = 1'b1;
      expected_matchings.push_back(m);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    matching_t m;
    if (rst) begin
      men_tab    = MEN_RANK_RESET;
      women_tab  = WOMEN_RANK_RESET;
      fail_count = 0;
      expected_matchings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_MEN_RANK, 2'b00}) men_tab = pwdata[TABLE_W-1:0];
        else if (paddr == {REG_WOMEN_RANK, 2'b00}) women_tab = pwdata[TABLE_W-1:0];
      end
      if (in_valid && in_ready && start_request) predict_matchings();
      if (out_valid && out_ready) begin
        if (expected_matchings.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %0h/%0h/%0b/%0b", $time,
                   wives_packed, solution_number, found, last);
          fail_count++;
        end else begin
          m = expected_matchings.pop_front();
          check_field("wives_packed", int'(m.wives), int'(wives_packed));
          check_field("solution_number", int'(m.number), int'(solution_number));
          check_field("found", int'(m.found), int'(found));
          check_field("last", int'(m.last), int'(last));
        end
      end
    end
    errors  <= fail_count;
    pending <= expected_matchings.size();
  end

endmodule

// ===== dv/tb.sv =====
// testbench top: clock, reset, start words, rank table writes, output stalls and verdict
`timescale 1ns / 1ps

module tb;
  import smenum_pkg::*;

  localparam int PHASES       = 14;
  localparam int RUNS_A_PHASE = 26;
  localparam int SETTLE       = 300;
  localparam int LONG_HOLD    = 600;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  start_request;
  logic                  out_valid;
  logic                  out_ready;
  logic [WIVES_W-1:0]    wives_packed;
  logic [SOL_W-1:0]      solution_number;
  logic                  found;
  logic                  last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   errors;
  int   pending;
  int   tx_idle;
  int   rx_idle;
  logic hold_req;
  logic hold_done;

  stable_matching_enumerator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .start_request(start_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .wives_packed(wives_packed), .solution_number(solution_number),
    .found(found), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  smenum_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .start_request(start_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .wives_packed(wives_packed), .solution_number(solution_number),
    .found(found), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off that backs the block up
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // word stays offered until taken, then a random gap
  task automatic send_word(input logic req);
    in_valid      <= 1'b1;
    start_request <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_table(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // tables are only rewritten once the block has gone quiet
  task automatic load_tables(input logic [APB_DATA_W-1:0] men, input logic [APB_DATA_W-1:0] women);
    in_valid <= 1'b0;
    // the pending count of the last start is registered by the checker before it shows
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_table(REG_MEN_RANK, men);
    write_table(REG_WOMEN_RANK, women);
  endtask

  // every row a permutation of ranks, so preferences are strict
  function automatic logic [APB_DATA_W-1:0] strict_table();
    logic [APB_DATA_W-1:0] t;
    int                    r [PEOPLE_DEFAULT];
    int                    j;
    int                    tmp;
    t = $urandom & ~((32'd1 << TABLE_W) - 1);
    for (int row = 0; row < PEOPLE_DEFAULT; row++) begin
      for (int k = 0; k < PEOPLE_DEFAULT; k++) r[k] = k;
      for (int k = PEOPLE_DEFAULT - 1; k > 0; k--) begin
        j    = $urandom_range(k);
        tmp  = r[k];
        r[k] = r[j];
        r[j] = tmp;
      end
      for (int col = 0; col < PEOPLE_DEFAULT; col++)
        t[2 * (row * PEOPLE_DEFAULT + col) +: 2] = r[col][1:0];
    end
    return t;
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_table();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    else if (sel < 9) return strict_table();
    else if ($urandom_range(1) == 1) return $urandom | ((32'd1 << TABLE_W) - 1);
    else return $urandom & ~((32'd1 << TABLE_W) - 1);
  endfunction

  initial begin
    int runs;
    rst           = 1'b1;
    in_valid      = 1'b0;
    start_request = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    tx_idle       = 0;
    rx_idle       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default tables, an ignored word, the table extremes, strict tables, then constant mid ranks
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    load_tables(32'h0, 32'h0);
    send_word(1'b1);
    load_tables(32'h3FFFF, 32'h3FFFF);
    send_word(1'b1);
    send_word(1'b1);
    load_tables(32'h0, 32'h3FFFF);
    send_word(1'b1);
    load_tables(32'hFFFF_FFFF, 32'hFFFC_0000);
    send_word(1'b1);
    load_tables(strict_table(), strict_table());
    send_word(1'b1);
    send_word(1'b0);
    load_tables(strict_table(), strict_table());
    send_word(1'b1);
    load_tables({14'h2AAA, 18'h15555}, {14'h1555, 18'h2AAAA});
    send_word(1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      load_tables(pick_table(), pick_table());
      if (ph < PHASES / 3) begin
        tx_idle = 38;
        rx_idle = 77;
      end else if (ph < 2 * PHASES / 3) begin
        tx_idle = 77;
        rx_idle = 38;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (ph == 2 * PHASES / 3) hold_req <= 1'b1;
      runs = 0;
      while (runs < RUNS_A_PHASE) begin
        if ($urandom_range(99) < 15) begin
          send_word(1'b0);
        end else begin
          send_word(1'b1);
          runs++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
